// ===== design/bls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the band level smoother
// Field widths, register codes and the control bundle of the level store.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int BAND_W      = 3;
    localparam int SAMPLE_IN_W = 10;
    localparam int LEVEL_W     = 24;
    localparam int AMP_W       = 16;
    localparam int FACTOR_W    = 9;
    localparam int TABLE_W     = 63;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int DVD_W       = 32;
    localparam int QUO_W       = 16;
    localparam int MUL_A_W     = 26;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 24'd16776960;
    localparam logic [AMP_W-1:0]   AMP_RESET   = 16'd255;
    localparam logic [TABLE_W-1:0] TABLE_RESET = 63'd4620710844295151872;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_LOW  = 3'd0,
        REG_WINDOW_HIGH = 3'd1,
        REG_AMP_MAX     = 3'd2,
        REG_SMOOTHING   = 3'd3,
        REG_STEREO_MODE = 3'd4,
        REG_BASS_SUM    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic wr_en;
        logic chan;
        logic bass;
    } lvl_ctrl_t;

endpackage

// ===== design/bls_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_divider: iterative restoring divider
// Divides a 32-bit dividend by a 16-bit divisor, one quotient bit a cycle.
// The quotient must fit in 16 bits, so the upper dividend half seeds the
// partial remainder.
// ----------------------------------------------------------------------------
module bls_divider
    import bls_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [QUO_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] dsr_reg;
    logic [QUO_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= dividend[DVD_W-1:QUO_W];
                quo_reg  <= dividend[QUO_W-1:0];
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? QUO_W'(trial - {1'b0, dsr_reg}) : trial[QUO_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/bls_level_file.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_level_file: per-band left and right level store
// Holds the smoothed levels, writes one channel per update and performs
// the band zero averaging of both channels.
// ----------------------------------------------------------------------------
module bls_level_file
    import bls_pkg::*;
#(
    parameter int BAND_COUNT = 7,
    parameter int IDX_W      = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lvl_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]   idx,
    input  logic [LEVEL_W-1:0] wr_data,
    output logic [LEVEL_W-1:0] rd_left,
    output logic [LEVEL_W-1:0] rd_right
);

    logic [LEVEL_W-1:0] left_reg  [BAND_COUNT];
    logic [LEVEL_W-1:0] right_reg [BAND_COUNT];
    logic [LEVEL_W:0]   pair_sum;

    assign pair_sum = {1'b0, left_reg[0]} + {1'b0, right_reg[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BAND_COUNT; i++) begin
                left_reg[i]  <= '0;
                right_reg[i] <= '0;
            end
        end else if (ctrl.bass) begin
            left_reg[0]  <= pair_sum[LEVEL_W:1];
            right_reg[0] <= pair_sum[LEVEL_W:1];
        end else if (ctrl.wr_en) begin
            if (ctrl.chan) begin
                right_reg[idx] <= wr_data;
            end else begin
                left_reg[idx] <= wr_data;
            end
        end
    end

    assign rd_left  = left_reg[idx];
    assign rd_right = right_reg[idx];

endmodule

// ===== design/band_level_smoother_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_level_smoother_top: per-band exponential moving average of two channels
// Scales each sample into the amplitude range and smooths it into the level
// of its band, using one shared multiplier and one iterative divider.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: band, left_sample, right_sample
//  m_axis    out        tdata: band_out, left_level, right_level
//  cfg       in         cfg_wen, cfg_addr, cfg_wdata (write only)
//
//  Each item runs through to its result before the next one is accepted; most
//  of the work is the 16 quotient steps of the divider per channel, and an
//  empty window skips them. An out-of-range band goes straight to the output
//  step.
//  A new item is taken while the previous result still waits on m_axis, and
//  a stalled result holds the block in its output step until it is taken.
//  Reset is synchronous, active low, and clears all levels at once.
// ----------------------------------------------------------------------------
module band_level_smoother_top
    import bls_pkg::*;
#(
    parameter int BAND_COUNT  = 7,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // band, left_sample, right_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // band_out, left_level, right_level
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int IN_W  = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
    localparam logic [SAMPLE_BITS-1:0] WIN_HIGH_RESET = SAMPLE_BITS'(1023);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DSTART,
        ST_DIV,
        ST_MULE,
        ST_UPD,
        ST_BASS,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic                     chan_reg;
    logic                     oor_reg;
    logic [BAND_W-1:0]        band_reg;
    logic [SAMPLE_IN_W-1:0]   ls_reg;
    logic [SAMPLE_IN_W-1:0]   rs_reg;
    logic [SAMPLE_BITS-1:0]   d_reg;
    logic [AMP_W-1:0]         scaled_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     m_tvalid_reg;
    logic [BAND_W-1:0]        band_out_reg;
    logic [LEVEL_W-1:0]       left_out_reg;
    logic [LEVEL_W-1:0]       right_out_reg;

    logic [SAMPLE_BITS-1:0]   win_low_reg;
    logic [SAMPLE_BITS-1:0]   win_high_reg;
    logic [AMP_W-1:0]         amp_max_reg;
    logic [TABLE_W-1:0]       table_reg;
    logic                     stereo_reg;
    logic                     bass_reg;

    logic [SAMPLE_BITS-1:0]   sample;
    logic [SAMPLE_BITS-1:0]   clamped;
    logic                     win_empty;
    logic [FACTOR_W-1:0]      factor;
    logic [IDX_W-1:0]         band_idx;
    logic [LEVEL_W-1:0]       rd_left;
    logic [LEVEL_W-1:0]       rd_right;
    logic [LEVEL_W-1:0]       level_cur;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [28:0]       new_sum;
    logic [LEVEL_W-1:0]       new_level;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic                     out_load;
    lvl_ctrl_t                lvl_ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_low_reg  <= '0;
            win_high_reg <= WIN_HIGH_RESET;
            amp_max_reg  <= AMP_RESET;
            table_reg    <= TABLE_RESET;
            stereo_reg   <= 1'b1;
            bass_reg     <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_WINDOW_LOW:  win_low_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_WINDOW_HIGH: win_high_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_AMP_MAX:     amp_max_reg  <= cfg_wdata[AMP_W-1:0];
                REG_SMOOTHING:   table_reg    <= cfg_wdata[TABLE_W-1:0];
                REG_STEREO_MODE: stereo_reg   <= cfg_wdata[0];
                REG_BASS_SUM:    bass_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign band_idx  = band_reg[IDX_W-1:0];
    assign factor    = FACTOR_W'(table_reg >> (FACTOR_W * band_reg));
    assign sample    = chan_reg ? SAMPLE_BITS'(rs_reg[IN_W-1:0])
                                : SAMPLE_BITS'(ls_reg[IN_W-1:0]);
    assign win_empty = win_high_reg <= win_low_reg;
    assign clamped   = (sample < win_low_reg)  ? win_low_reg  :
                       (sample > win_high_reg) ? win_high_reg : sample;
    assign level_cur = chan_reg ? rd_right : rd_left;

    always_comb begin
        if (state_reg == ST_SCALE) begin
            mul_a = MUL_A_W'(clamped - win_low_reg);
            mul_b = MUL_B_W'(amp_max_reg);
        end else begin
            mul_a = $signed({2'b00, scaled_reg, 8'h00}) - $signed({2'b00, level_cur});
            mul_b = $signed({9'b0, factor});
        end
    end

    assign product = mul_a * mul_b;

    // The arithmetic shift by eight floors the product toward minus infinity.
    assign new_sum   = $signed({5'b0, level_cur}) + prod_reg[36:8];
    assign new_level = new_sum[28] ? '0 :
                       (new_sum > $signed({5'b0, LEVEL_MAX})) ? LEVEL_MAX :
                       new_sum[LEVEL_W-1:0];

    assign lvl_ctrl.wr_en = state_reg == ST_UPD;
    assign lvl_ctrl.chan  = chan_reg;
    assign lvl_ctrl.bass  = state_reg == ST_BASS;

    assign div_start = state_reg == ST_DSTART;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    bls_level_file #(
        .BAND_COUNT(BAND_COUNT),
        .IDX_W     (IDX_W)
    ) u_levels (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lvl_ctrl),
        .idx     (band_idx),
        .wr_data (new_level),
        .rd_left (rd_left),
        .rd_right(rd_right)
    );

    bls_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(prod_reg[DVD_W-1:0]),
        .divisor (QUO_W'(d_reg)),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        band_reg  <= s_tdata[2:0];
                        ls_reg    <= s_tdata[12:3];
                        rs_reg    <= s_tdata[22:13];
                        oor_reg   <= 32'(s_tdata[2:0]) >= BAND_COUNT;
                        chan_reg  <= 1'b0;
                        state_reg <= (32'(s_tdata[2:0]) >= BAND_COUNT) ? ST_OUT : ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (win_empty) begin
                        scaled_reg <= '0;
                        state_reg  <= ST_MULE;
                    end else begin
                        prod_reg  <= product;
                        d_reg     <= win_high_reg - win_low_reg;
                        state_reg <= ST_DSTART;
                    end
                end
                ST_DSTART: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        scaled_reg <= div_quo;
                        state_reg  <= ST_MULE;
                    end
                end
                ST_MULE: begin
                    prod_reg  <= product;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (!chan_reg && stereo_reg) begin
                        chan_reg  <= 1'b1;
                        state_reg <= ST_SCALE;
                    end else if (stereo_reg && bass_reg && band_reg == '0) begin
                        state_reg <= ST_BASS;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_BASS: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_tvalid_reg  <= 1'b1;
                        band_out_reg  <= band_reg;
                        left_out_reg  <= oor_reg ? '0 : rd_left;
                        right_out_reg <= oor_reg ? '0 : rd_right;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, right_out_reg, left_out_reg, band_out_reg};

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && 32'(band_out_reg) >= BAND_COUNT
        |-> left_out_reg == '0 && right_out_reg == '0)
        else $error("out-of-range band item carries nonzero levels");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_ctrl.wr_en |-> new_level <= LEVEL_MAX)
        else $error("level written above the 16.8 maximum");

    a_mono_left_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) && chan_reg |-> stereo_reg)
        else $error("right level updated in mono mode");

    a_out_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result item not presented after load");

endmodule

// ===== sim/bls_level_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_level_checker: result checker of the band level smoother
// Watches the configuration port and both stream channels. It keeps its own
// copy of the registers and of the per-band levels, predicts the levels of
// every accepted input item and compares each accepted result, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bls_level_checker
    import bls_pkg::*;
#(
    parameter int BAND_COUNT = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,   // band, left_sample, right_sample
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [55:0]           m_tdata,   // band_out, left_level, right_level
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [LEVEL_W-1:0] right;
        logic [LEVEL_W-1:0] left;
        logic [BAND_W-1:0]  band;
    } band_levels_t;

    band_levels_t             level_queue[$];
    logic [LEVEL_W-1:0]       left_store [BAND_COUNT];
    logic [LEVEL_W-1:0]       right_store[BAND_COUNT];
    logic [SAMPLE_IN_W-1:0]   win_low;
    logic [SAMPLE_IN_W-1:0]   win_high;
    logic [AMP_W-1:0]         amp_max;
    logic [TABLE_W-1:0]       factors;
    logic                     stereo;
    logic                     bass_sum;

    function automatic logic [AMP_W-1:0] scale_amp(input logic [SAMPLE_IN_W-1:0] sample);
        logic [SAMPLE_IN_W-1:0] clamped;
        longint unsigned        numer;
        longint unsigned        span;
        if (win_high <= win_low) begin
            return '0;
        end
        clamped = sample;
        if (clamped < win_low) begin
            clamped = win_low;
        end
        if (clamped > win_high) begin
            clamped = win_high;
        end
        numer = 64'(clamped - win_low);
        numer = numer * 64'(amp_max);
        span  = 64'(win_high - win_low);
        return AMP_W'(numer / span);
    endfunction

    function automatic logic [LEVEL_W-1:0] ema_step(input logic [LEVEL_W-1:0] level,
                                                    input logic [AMP_W-1:0]   amp,
                                                    input logic [FACTOR_W-1:0] f);
        longint diff;
        longint prod;
        longint sum;
        diff = longint'({amp, 8'd0}) - longint'(level);
        prod = diff * longint'(f);
        // The arithmetic shift floors toward minus infinity.
        sum  = longint'(level) + (prod >>> 8);
        if (sum < 0) begin
            return '0;
        end
        if (sum > longint'(LEVEL_MAX)) begin
            return LEVEL_MAX;
        end
        return sum[LEVEL_W-1:0];
    endfunction

    function automatic band_levels_t advance_levels(input logic [23:0] item);
        band_levels_t        res;
        logic [FACTOR_W-1:0] f;
        logic [LEVEL_W:0]    total;
        int                  b;
        b        = int'(item[2:0]);
        res.band = item[2:0];
        if (b >= BAND_COUNT) begin
            res.left  = '0;
            res.right = '0;
            return res;
        end
        f = factors[FACTOR_W*b +: FACTOR_W];
        left_store[b] = ema_step(left_store[b], scale_amp(item[12:3]), f);
        if (stereo) begin
            right_store[b] = ema_step(right_store[b], scale_amp(item[22:13]), f);
            if (bass_sum && b == 0) begin
                total          = {1'b0, left_store[0]} + {1'b0, right_store[0]};
                left_store[0]  = total[LEVEL_W:1];
                right_store[0] = total[LEVEL_W:1];
            end
        end
        res.left  = left_store[b];
        res.right = right_store[b];
        return res;
    endfunction

    always @(posedge aclk) begin
        band_levels_t got;
        band_levels_t want;
        if (!aresetn) begin
            fail_count = 0;
            win_low  = '0;
            win_high = SAMPLE_IN_W'(1023);
            amp_max  = AMP_RESET;
            factors  = TABLE_RESET;
            stereo   = 1'b1;
            bass_sum = 1'b0;
            for (int i = 0; i < BAND_COUNT; i++) begin
                left_store[i]  = '0;
                right_store[i] = '0;
            end
            level_queue.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    REG_WINDOW_LOW:  win_low  = cfg_wdata[SAMPLE_IN_W-1:0];
                    REG_WINDOW_HIGH: win_high = cfg_wdata[SAMPLE_IN_W-1:0];
                    REG_AMP_MAX:     amp_max  = cfg_wdata[AMP_W-1:0];
                    REG_SMOOTHING:   factors  = cfg_wdata[TABLE_W-1:0];
                    REG_STEREO_MODE: stereo   = cfg_wdata[0];
                    REG_BASS_SUM:    bass_sum = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(band_levels_t)-1:0];
                if (level_queue.size() == 0) begin
                    $display("%0t: unexpected result: band %0d left %0d right %0d",
                             $time, got.band, got.left, got.right);
                    fail_count++;
                end else begin
                    want = level_queue.pop_front();
                    if (got.band !== want.band) begin
                        $display("%0t: band_out expected %0d, actual %0d",
                                 $time, want.band, got.band);
                        fail_count++;
                    end
                    if (got.left !== want.left) begin
                        $display("%0t: band %0d left_level expected %0d, actual %0d",
                                 $time, want.band, want.left, got.left);
                        fail_count++;
                    end
                    if (got.right !== want.right) begin
                        $display("%0t: band %0d right_level expected %0d, actual %0d",
                                 $time, want.band, want.right, got.right);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                level_queue.push_back(advance_levels(s_tdata));
            end
        end
        pending = level_queue.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the band level smoother
// Drives sample pairs into the block under a series of register settings,
// first a short directed set of corner cases, then random items in phases
// with and without idling on either side. A separate checker predicts and
// compares the levels; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bls_pkg::*;

    localparam int                    CYCLE_LIMIT  = 1000000;
    localparam int                    SEGMENTS     = 16;
    localparam int                    SEGMENT_SIZE = 96;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7  = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // band, left_sample, right_sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [55:0]           m_tdata;          // band_out, left_level, right_level
    logic                  cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    always #10 aclk = ~aclk;

    band_level_smoother_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bls_level_checker i_level_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic offer_pair(input logic [2:0] band, input logic [9:0] left,
                              input logic [9:0] right);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, right, left, band};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_levels_out(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Every setting also writes one of the unused indexes, which must have no effect.
    task automatic program_settings(input logic [9:0] lo, input logic [9:0] hi,
                                    input logic [15:0] amp, input logic [62:0] tbl,
                                    input logic stereo, input logic bass);
        wait_levels_out(4);
        write_reg(REG_WINDOW_LOW, CFG_DATA_W'(lo));
        write_reg(REG_WINDOW_HIGH, CFG_DATA_W'(hi));
        write_reg(REG_AMP_MAX, CFG_DATA_W'(amp));
        write_reg(REG_SMOOTHING, CFG_DATA_W'(tbl));
        write_reg(REG_STEREO_MODE, CFG_DATA_W'(stereo));
        write_reg(REG_BASS_SUM, CFG_DATA_W'(bass));
        write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7,
                  CFG_DATA_W'({$urandom, $urandom}));
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [15:0] amp;
        logic [62:0] tbl;
        logic [8:0]  f;
        logic [2:0]  band;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults, extremes of the samples and a band beyond the last one.
        program_settings(10'd0, 10'd1023, AMP_RESET, TABLE_RESET, 1'b1, 1'b0);
        offer_pair(3'd0, 10'd1023, 10'd0);
        offer_pair(3'd6, 10'd0, 10'd1023);
        offer_pair(3'd7, 10'd1023, 10'd1023);
        offer_pair(3'd3, 10'd512, 10'd511);

        // Full factor and full amplitude land exactly on the largest level.
        program_settings(10'd0, 10'd1023, 16'hFFFF, {7{9'd256}}, 1'b1, 1'b0);
        offer_pair(3'd0, 10'd1023, 10'd1023);
        offer_pair(3'd6, 10'd1023, 10'd1023);

        // Factors above one overshoot and saturate at the lower end.
        program_settings(10'd0, 10'd1023, 16'hFFFF, {7{9'd511}}, 1'b1, 1'b0);
        offer_pair(3'd0, 10'd1023, 10'd1023);
        offer_pair(3'd0, 10'd0, 10'd0);
        offer_pair(3'd6, 10'd0, 10'd1023);

        // Empty windows, equal bounds and inverted bounds.
        program_settings(10'd1023, 10'd1023, 16'd300, {7{9'd128}}, 1'b1, 1'b0);
        offer_pair(3'd1, 10'd1023, 10'd0);
        offer_pair(3'd2, 10'd0, 10'd1023);
        program_settings(10'd900, 10'd100, 16'd300, {7{9'd200}}, 1'b1, 1'b0);
        offer_pair(3'd1, 10'd1023, 10'd0);
        offer_pair(3'd2, 10'd0, 10'd1023);

        // Samples outside the window are clamped.
        program_settings(10'd100, 10'd900, 16'd1000, 63'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
        offer_pair(3'd4, 10'd0, 10'd1023);
        offer_pair(3'd4, 10'd1023, 10'd50);
        offer_pair(3'd5, 10'd100, 10'd900);

        // Mono mode ignores the right sample and the bass sum.
        program_settings(10'd0, 10'd1023, 16'd4000, {7{9'd64}}, 1'b0, 1'b1);
        offer_pair(3'd0, 10'd800, 10'd300);
        offer_pair(3'd5, 10'd1023, 10'd1023);

        // Stereo with the bass sum averages band 0 only.
        program_settings(10'd0, 10'd1023, 16'd4000, {7{9'd100}}, 1'b1, 1'b1);
        offer_pair(3'd0, 10'd1023, 10'd0);
        offer_pair(3'd0, 10'd0, 10'd1023);
        offer_pair(3'd1, 10'd700, 10'd20);

        // A zero factor holds the levels.
        program_settings(10'd0, 10'd1023, 16'hFFFF, '0, 1'b1, 1'b0);
        offer_pair(3'd2, 10'd1023, 10'd1023);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(7))
                0: begin
                    lo = 10'd0;
                    hi = 10'd1023;
                end
                1: begin
                    lo = 10'($urandom_range(1023));
                    hi = lo;
                end
                2: begin
                    lo = 10'($urandom_range(1023, 1));
                    hi = 10'($urandom_range(lo - 1));
                end
                default: begin
                    lo = 10'($urandom_range(600));
                    hi = 10'($urandom_range(1023, lo + 1));
                end
            endcase
            case ($urandom_range(5))
                0:       amp = 16'd0;
                1:       amp = 16'hFFFF;
                default: amp = 16'($urandom_range(16'hFFFF));
            endcase
            for (int k = 0; k < 7; k++) begin
                case ($urandom_range(7))
                    0:       f = 9'd0;
                    1:       f = 9'd256;
                    2:       f = 9'($urandom_range(511, 257));
                    default: f = 9'($urandom_range(255, 1));
                endcase
                tbl[9*k +: 9] = f;
            end
            case (seg % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 75;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 75;
                end
                default: begin
                    tx_idle_pct  = 13;
                    rx_stall_pct = 13;
                end
            endcase
            program_settings(lo, hi, amp, tbl, $urandom_range(3) != 0,
                             1'($urandom_range(1)));
            for (int n = 0; n < SEGMENT_SIZE; n++) begin
                band = ($urandom_range(15) == 0) ? 3'd7 : 3'($urandom_range(6));
                offer_pair(band, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
            end
        end

        wait_levels_out(60);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
